// ===== design/fcs_pkg.sv =====
package fcs_pkg;

    localparam int POS_W = 17;
    localparam int SIZE_W = POS_W + 1;
    localparam int LEN_W = 16;
    localparam int CFG_INDEX_W = 8;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HEADER = 17'd0;
    localparam logic [POS_W-1:0] POS_CODE = 17'd1;
    localparam logic [POS_W-1:0] POS_NUMBER = 17'd2;
    localparam logic [POS_W-1:0] POS_COUNTER = 17'd3;
    localparam logic [POS_W-1:0] POS_LEN_HI = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO = 17'd5;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 17'd6;

    // sum starts adding lagged bytes once this position is reached
    localparam logic [POS_W-1:0] POS_SUM_START = 17'd3;

    localparam logic [SIZE_W-1:0] MIN_FRAME = 18'd8;

    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam logic [7:0] TAIL_RESET = 8'h55;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL = 8'd1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_BAD_TAIL = 3'd3,
        ST_LEN_MISMATCH = 3'd4,
        ST_BAD_CHECKSUM = 3'd5
    } fcs_status_t;

    // packed so that payload_byte sits in the lowest bits
    typedef struct packed {
        logic [4:0]       pad;
        logic [7:0]       received_sum;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       frame_counter;
        logic [7:0]       frame_number;
        logic [7:0]       ctrl_byte;
        fcs_status_t      status;
        logic [7:0]       payload_byte;
    } fcs_fields_t;

    typedef struct packed {
        logic        kind;
        fcs_fields_t fields;
    } fcs_result_t;

endpackage

// ===== design/fcs_parser.sv =====
module fcs_parser
    import fcs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   beat_accept,
    input  logic [7:0]             rx_byte,
    input  logic                   end_of_buffer,
    output logic                   res_valid,
    output fcs_result_t            res_data
);

    logic [7:0]       header_value_reg;
    logic [7:0]       tail_value_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             hdr_ok_reg, hdr_ok_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       number_reg, number_next;
    logic [7:0]       count_reg, count_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       lag0_reg, lag0_next;
    logic [7:0]       lag1_reg, lag1_next;
    logic [7:0]       chk_reg, chk_next;

    logic [POS_W-1:0]  chk_pos;
    logic [SIZE_W-1:0] size;
    logic              in_payload;
    fcs_status_t       status;

    always_comb begin
        hdr_ok_next = hdr_ok_reg;
        code_next = code_reg;
        number_next = number_reg;
        count_next = count_reg;
        len_next = len_reg;

        unique case (pos_reg)
            POS_HEADER:  hdr_ok_next = (rx_byte == header_value_reg);
            POS_CODE:    code_next = rx_byte;
            POS_NUMBER:  number_next = rx_byte;
            POS_COUNTER: count_next = rx_byte;
            POS_LEN_HI:  len_next = {rx_byte, 8'h00};
            POS_LEN_LO:  len_next = {len_reg[15:8], rx_byte};
            default:     ;
        endcase

        // length is settled once the payload region is reached
        chk_pos = {1'b0, len_reg} + POS_PAYLOAD;
        chk_next = (pos_reg >= POS_PAYLOAD && pos_reg == chk_pos) ? rx_byte : chk_reg;
        sum_next = (pos_reg >= POS_SUM_START) ? sum_reg + lag1_reg : sum_reg;
        lag1_next = lag0_reg;
        lag0_next = rx_byte;

        in_payload = hdr_ok_next && (pos_reg >= POS_PAYLOAD) && (pos_reg < chk_pos);
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 17'd1;

        size = {1'b0, pos_reg} + 18'd1;
        priority if (size < MIN_FRAME) begin
            status = ST_TOO_SHORT;
        end else if (!hdr_ok_next) begin
            status = ST_BAD_HEADER;
        end else if (rx_byte != tail_value_reg) begin
            status = ST_BAD_TAIL;
        end else if (size < ({2'b00, len_next} + MIN_FRAME)) begin
            status = ST_LEN_MISMATCH;
        end else if (sum_next != chk_next) begin
            status = ST_BAD_CHECKSUM;
        end else begin
            status = ST_OK;
        end

        res_data = '0;
        if (end_of_buffer) begin
            res_valid = beat_accept;
            res_data.kind = KIND_STATUS;
            res_data.fields.status = status;
            res_data.fields.ctrl_byte = code_next;
            res_data.fields.frame_number = number_next;
            res_data.fields.frame_counter = count_next;
            res_data.fields.payload_length = len_next;
            res_data.fields.received_sum = chk_next;
        end else begin
            res_valid = beat_accept && in_payload;
            res_data.kind = KIND_PAYLOAD;
            res_data.fields.payload_byte = rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_value_reg <= HEADER_RESET;
            tail_value_reg <= TAIL_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_HEADER) begin
                header_value_reg <= cfg_data;
            end
            if (cfg_index == REG_TAIL) begin
                tail_value_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_accept && end_of_buffer)) begin
            // frame state starts over after every end result
            pos_reg <= '0;
            hdr_ok_reg <= 1'b0;
            code_reg <= '0;
            number_reg <= '0;
            count_reg <= '0;
            len_reg <= '0;
            sum_reg <= '0;
            lag0_reg <= '0;
            lag1_reg <= '0;
            chk_reg <= '0;
        end else if (beat_accept) begin
            pos_reg <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            code_reg <= code_next;
            number_reg <= number_next;
            count_reg <= count_next;
            len_reg <= len_next;
            sum_reg <= sum_next;
            lag0_reg <= lag0_next;
            lag1_reg <= lag1_next;
            chk_reg <= chk_next;
        end
    end

endmodule

// ===== design/fcs_out_buf.sv =====
module fcs_out_buf
    import fcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  fcs_result_t in_data,
    output logic        in_ready,
    output logic        out_valid,
    output fcs_result_t out_data,
    input  logic        out_ready
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    fcs_result_t main_data_reg, main_data_next;
    fcs_result_t skid_data_reg, skid_data_next;

    assign in_ready = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next = skid_data_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                // no new beat can arrive while the skid slot is full
                main_valid_next = 1'b1;
                main_data_next = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                main_data_next = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== design/frame_checker_with_sum_checksum_top.sv =====
// Frame checker: takes a received buffer one byte per beat (tlast on the last byte)
// and checks header, tail, length and an 8-bit additive checksum over bytes 1 to
// size-3. Payload bytes of a frame whose header matched leave as kind-0 beats
// (m_tuser = 0); the last byte of the buffer yields one kind-1 beat with the
// status and the header fields. One byte is accepted every clock cycle while
// s_tready is high; results are registered in the output buffer. The per-byte
// update is a checksum add plus position compares on the frame state registers,
// and a two-entry output buffer keeps s_tready high until its skid entry fills.
// Header and tail bytes are set through the cfg port (index 0 and 1), which is
// always ready and should be written only while no frame is in flight.
module frame_checker_with_sum_checksum_top
    import fcs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // rx_byte
    input  logic                   s_tlast,   // end_of_buffer

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // payload_byte[7:0], status[10:8], ctrl_byte[18:11], frame_number[26:19],
    // frame_counter[34:27], payload_length[50:35], received_sum[58:51], zero[63:59]
    output logic [63:0]            m_tdata,
    output logic                   m_tuser    // kind
);

    logic        beat_accept;
    logic        res_valid;
    fcs_result_t res_data;
    fcs_result_t out_data;

    assign cfg_ready = 1'b1;
    assign beat_accept = s_tvalid && s_tready;

    fcs_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .beat_accept   (beat_accept),
        .rx_byte       (s_tdata),
        .end_of_buffer (s_tlast),
        .res_valid     (res_valid),
        .res_data      (res_data)
    );

    fcs_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res_data),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = out_data.fields;
    assign m_tuser = out_data.kind;

endmodule
